[hdl/lpto_pkg.sv]
// ----------------------------------------------------------------------------
// lpto_pkg
// Shared types and constants of the preemptive LIFO task order block.
// ----------------------------------------------------------------------------
package lpto_pkg;

	localparam int IdW     = 10;
	localparam int StartW  = 11;
	localparam int DurW    = 10;
	localparam int EndW    = 12;
	localparam int RemW    = 10;
	localparam int StatusW = 2;
	localparam int IdleW   = 11;
	localparam int EntryW  = IdW + RemW;

	// Result status codes.
	localparam logic [StatusW-1:0] ST_OK       = 2'd0;
	localparam logic [StatusW-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [StatusW-1:0] ST_ORDER    = 2'd2;

	// Source of a produced result.
	localparam logic [1:0] SEL_RUN_OK  = 2'd0;
	localparam logic [1:0] SEL_RUN_OVF = 2'd1;
	localparam logic [1:0] SEL_ORDER   = 2'd2;
	localparam logic [1:0] SEL_TOP     = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       load_run;
		logic       push;
		logic       produce;
		logic [1:0] prod_sel;
		logic       pop;
		logic       load_top;
		logic       shrink;
		logic       set_idle;
		logic       clear_all;
		logic       finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic flush;
		logic order_err;
		logic run_valid;
		logic preempt;
		logic stack_full;
		logic stack_empty;
		logic idle_zero;
		logic covers;
		logic pend_valid;
		logic out_free;
	} dp_stat_t;

endpackage

[hdl/lifo_preemptive_task_order.sv]
// ----------------------------------------------------------------------------
// lifo_preemptive_task_order
// Preemptive LIFO task scheduler: reports completed task ids per arrival and
// drains the running task and the pause stack on an end-of-batch command.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | tdata (low bit up)                          | tuser      | tlast
// s_axis   | in  | task_id[9:0] start_minute[20:10] dur[30:21] | command    | -
// m_axis   | out | done_id[9:0], zero filled to 16 bits        | status[1:0]| last
//
// Steps: an item that is rejected, preempts or simply starts running passes
// through accept, decide and release of its final result. A completion or a
// flush adds a walk of the pause stack, plus a pop and a refill of the cached
// top for each paused task popped from it. The refill comes from the stack
// RAM's registered read; shrinking the top happens in the walk state.
// Reset is asynchronous and active low; the stack RAM is never cleared, since
// only entries below the fill count are ever read.
// A stalled m_axis holds the controller at its next result; s_axis is taken
// only when the previous item's results have all left the pending register.
//
module lifo_preemptive_task_order #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // task_id, start_minute, duration, pad bit
	input  logic        s_axis_tuser,  // command

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // done_id, zero pad
	output logic [1:0]  m_axis_tuser,  // status
	output logic        m_axis_tlast
);

	lpto_pkg::dp_cmd_t              cmd;
	lpto_pkg::dp_stat_t             stat;
	logic [lpto_pkg::IdW-1:0]       done_id;

	// The controller only sequences; all task and result state lives in the datapath.
	lpto_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpto_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_command (s_axis_tuser),
		.in_id      (s_axis_tdata[9:0]),
		.in_start   (s_axis_tdata[20:10]),
		.in_dur     (s_axis_tdata[30:21]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_id     (done_id),
		.out_status (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

	// Upper tdata bits are padding and always read as zero.
	assign m_axis_tdata = {6'd0, done_id};

endmodule

[hdl/lpto_ram.sv]
// ----------------------------------------------------------------------------
// lpto_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lpto_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/lpto_dp.sv]
// ----------------------------------------------------------------------------
// lpto_dp
// Datapath: captured item, running task, cached stack top, pause stack RAM,
// idle gap, pending result and output register.
// ----------------------------------------------------------------------------
module lpto_dp #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpto_pkg::dp_cmd_t           cmd,
	output lpto_pkg::dp_stat_t          stat,
	input  logic                        in_command,
	input  logic [lpto_pkg::IdW-1:0]    in_id,
	input  logic [lpto_pkg::StartW-1:0] in_start,
	input  logic [lpto_pkg::DurW-1:0]   in_dur,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lpto_pkg::IdW-1:0]    out_id,
	output logic [lpto_pkg::StatusW-1:0] out_status,
	output logic                        out_last
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// Captured input item.
	logic                          cmd_q;
	logic [lpto_pkg::IdW-1:0]      id_q;
	logic [lpto_pkg::StartW-1:0]   start_q;
	logic [lpto_pkg::DurW-1:0]     dur_q;

	// Task state.
	logic                          run_valid_q;
	logic [lpto_pkg::IdW-1:0]      run_id_q;
	logic [lpto_pkg::EndW-1:0]     run_end_q;
	logic [lpto_pkg::StartW-1:0]   last_start_q;
	logic [CW-1:0]                 cnt_q;
	logic [lpto_pkg::EntryW-1:0]   top_q;
	logic [lpto_pkg::IdleW-1:0]    idle_q;

	// Pending result and output register.
	logic                          pend_valid_q;
	logic [lpto_pkg::IdW-1:0]      pend_id_q;
	logic [lpto_pkg::StatusW-1:0]  pend_status_q;
	logic                          out_valid_q;
	logic [lpto_pkg::IdW-1:0]      out_id_q;
	logic [lpto_pkg::StatusW-1:0]  out_status_q;
	logic                          out_last_q;

	logic [lpto_pkg::EndW-1:0]     start_ext;
	logic [lpto_pkg::EndW-1:0]     end_diff;
	logic [lpto_pkg::EndW-1:0]     gap;
	logic [lpto_pkg::RemW-1:0]     top_rem;
	logic [lpto_pkg::RemW-1:0]     shrunk_rem;
	logic [lpto_pkg::IdW-1:0]      prod_id;
	logic [lpto_pkg::StatusW-1:0]  prod_status;
	logic                          send;
	logic                          send_last;
	logic                          out_free;
	logic [CW-1:0]                 cnt_m1;
	logic [CW-1:0]                 cnt_m2;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [lpto_pkg::EntryW-1:0]   ram_wdata;
	logic [lpto_pkg::EntryW-1:0]   ram_rdata;

	assign start_ext  = {1'b0, start_q};
	assign end_diff   = run_end_q - start_ext;
	assign gap        = start_ext - run_end_q;
	assign top_rem    = top_q[lpto_pkg::RemW-1:0];
	assign shrunk_rem = top_rem - idle_q[lpto_pkg::RemW-1:0];
	assign cnt_m1     = cnt_q - CW'(1);
	assign cnt_m2     = cnt_q - CW'(2);
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		case (cmd.prod_sel)
			lpto_pkg::SEL_RUN_OK: begin
				prod_id     = run_id_q;
				prod_status = lpto_pkg::ST_OK;
			end
			lpto_pkg::SEL_RUN_OVF: begin
				prod_id     = run_id_q;
				prod_status = lpto_pkg::ST_OVERFLOW;
			end
			lpto_pkg::SEL_ORDER: begin
				prod_id     = '0;
				prod_status = lpto_pkg::ST_ORDER;
			end
			default: begin
				prod_id     = top_q[lpto_pkg::EntryW-1:lpto_pkg::RemW];
				prod_status = lpto_pkg::ST_OK;
			end
		endcase
	end

	// A pending result leaves once the next one is known (not last) or at the
	// end of the item (last).
	assign send      = pend_valid_q && (cmd.produce || cmd.finish);
	assign send_last = cmd.finish;

	always_comb begin
		ram_we    = cmd.push || cmd.shrink;
		ram_waddr = cmd.push ? cnt_q[AW-1:0] : cnt_m1[AW-1:0];
		ram_wdata = cmd.push ? {run_id_q, end_diff[lpto_pkg::RemW-1:0]}
		                     : {top_q[lpto_pkg::EntryW-1:lpto_pkg::RemW], shrunk_rem};
	end

	lpto_ram #(
		.WIDTH (lpto_pkg::EntryW),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q   <= in_command;
			id_q    <= in_id;
			start_q <= in_start;
			dur_q   <= in_dur;
		end
		if (cmd.load_run) begin
			run_id_q  <= id_q;
			run_end_q <= start_ext + {2'b00, dur_q};
		end else if (cmd.clear_all) begin
			run_id_q  <= '0;
			run_end_q <= '0;
		end
		if (cmd.push) begin
			top_q <= {run_id_q, end_diff[lpto_pkg::RemW-1:0]};
		end else if (cmd.shrink) begin
			top_q[lpto_pkg::RemW-1:0] <= shrunk_rem;
		end else if (cmd.load_top) begin
			top_q <= ram_rdata;
		end
		if (cmd.set_idle) begin
			idle_q <= gap[lpto_pkg::IdleW-1:0];
		end else if (cmd.pop) begin
			idle_q <= idle_q - {1'b0, top_rem};
		end else if (cmd.shrink) begin
			idle_q <= '0;
		end
		if (cmd.produce) begin
			pend_id_q     <= prod_id;
			pend_status_q <= prod_status;
		end
		if (send) begin
			out_id_q     <= pend_id_q;
			out_status_q <= pend_status_q;
			out_last_q   <= send_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q  <= 1'b0;
			last_start_q <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load_run) begin
				run_valid_q  <= 1'b1;
				last_start_q <= start_q;
			end else if (cmd.clear_all) begin
				run_valid_q  <= 1'b0;
				last_start_q <= '0;
			end
			if (cmd.push) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.pop) begin
				cnt_q <= cnt_m1;
			end else if (cmd.clear_all) begin
				cnt_q <= '0;
			end
			if (cmd.produce) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end
			if (send) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.flush       = cmd_q;
		stat.order_err   = start_q < last_start_q;
		stat.run_valid   = run_valid_q;
		stat.preempt     = start_ext < run_end_q;
		stat.stack_full  = cnt_q == CW'(STACK_DEPTH);
		stat.stack_empty = cnt_q == '0;
		stat.idle_zero   = idle_q == '0;
		stat.covers      = idle_q >= {1'b0, top_rem};
		stat.pend_valid  = pend_valid_q;
		stat.out_free    = out_free;
	end

	assign out_valid  = out_valid_q;
	assign out_id     = out_id_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("pause stack count beyond depth");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> cnt_q < CW'(STACK_DEPTH))
		else $error("push into a full pause stack");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> cnt_q != '0)
		else $error("pop from an empty pause stack");

	a_send_room: assert property (@(posedge clk) disable iff (!arst_n)
		send |-> out_free)
		else $error("result overwrites an untaken output");

	a_pop_refill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> cmd.load_top)
		else $error("stack top not refilled after pop");

endmodule

[hdl/lpto_ctrl.sv]
// ----------------------------------------------------------------------------
// lpto_ctrl
// Controller: sequences capture, decision, stack resume or flush, and the
// release of the final result of each item.
// ----------------------------------------------------------------------------
module lpto_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lpto_pkg::dp_stat_t  stat,
	output lpto_pkg::dp_cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_RESUME = 3'd2;
	localparam logic [2:0] S_FETCH  = 3'd3;
	localparam logic [2:0] S_FLUSH  = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       can_produce;

	assign can_produce = !stat.pend_valid || stat.out_free;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.flush) begin
					cmd.produce  = stat.run_valid;
					cmd.prod_sel = lpto_pkg::SEL_RUN_OK;
					state_d      = S_FLUSH;
				end else if (stat.order_err) begin
					cmd.produce  = 1'b1;
					cmd.prod_sel = lpto_pkg::SEL_ORDER;
					state_d      = S_FINISH;
				end else if (!stat.run_valid) begin
					cmd.load_run = 1'b1;
					state_d      = S_FINISH;
				end else if (stat.preempt) begin
					cmd.load_run = 1'b1;
					cmd.push     = !stat.stack_full;
					cmd.produce  = stat.stack_full;
					cmd.prod_sel = lpto_pkg::SEL_RUN_OVF;
					state_d      = S_FINISH;
				end else begin
					cmd.produce  = 1'b1;
					cmd.prod_sel = lpto_pkg::SEL_RUN_OK;
					cmd.set_idle = 1'b1;
					cmd.load_run = 1'b1;
					state_d      = S_RESUME;
				end
			end
			S_RESUME: begin
				if (stat.idle_zero || stat.stack_empty) begin
					state_d = S_FINISH;
				end else if (!stat.covers) begin
					cmd.shrink = 1'b1;
					state_d    = S_FINISH;
				end else if (can_produce) begin
					cmd.produce  = 1'b1;
					cmd.prod_sel = lpto_pkg::SEL_TOP;
					cmd.pop      = 1'b1;
					state_d      = S_FETCH;
				end
			end
			S_FETCH: begin
				cmd.load_top = 1'b1;
				state_d      = stat.flush ? S_FLUSH : S_RESUME;
			end
			S_FLUSH: begin
				if (stat.stack_empty) begin
					cmd.clear_all = 1'b1;
					state_d       = S_FINISH;
				end else if (can_produce) begin
					cmd.produce  = 1'b1;
					cmd.prod_sel = lpto_pkg::SEL_TOP;
					cmd.pop      = 1'b1;
					state_d      = S_FETCH;
				end
			end
			S_FINISH: begin
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !stat.pend_valid)
		else $error("item accepted while a result is still pending");

	a_finish_releases: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> stat.pend_valid && stat.out_free)
		else $error("final release without a pending result or room");

	a_one_stack_op: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.push, cmd.pop, cmd.shrink, cmd.load_top}) <= 1)
		else $error("conflicting stack operations");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the preemptive LIFO task order block. A table of
// directed transfers covers the corner cases, then about 140 random transfers
// follow. Both stream sides idle at random. Every result is checked against a
// cycle-free scheduler predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdW     = lpto_pkg::IdW;
	localparam int StartW  = lpto_pkg::StartW;
	localparam int DurW    = lpto_pkg::DurW;
	localparam int EndW    = lpto_pkg::EndW;
	localparam int RemW    = lpto_pkg::RemW;
	localparam int StatusW = lpto_pkg::StatusW;

	localparam logic [StatusW-1:0] ST_OK       = lpto_pkg::ST_OK;
	localparam logic [StatusW-1:0] ST_OVERFLOW = lpto_pkg::ST_OVERFLOW;
	localparam logic [StatusW-1:0] ST_ORDER    = lpto_pkg::ST_ORDER;

	localparam int SLOTS      = 16;
	localparam int N_RANDOM   = 141;
	localparam int HOLD_LEN   = 400;
	localparam int TAIL_WAIT  = 60;
	localparam int CYCLE_CAP  = 1_000_000;
	localparam int SHOW_LIMIT = 10;
	localparam int EXP_DEPTH  = 256;
	localparam int PLAN_SLOTS = 40;

	// Values carried on s_axis_tuser.
	localparam logic CMD_TASK  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// How a table row gets its expected results: from the predictor, typed in
	// as nothing at all, or typed in as one final result.
	typedef enum logic [1:0] {PIN_PREDICT, PIN_SILENT, PIN_ONE} pin_t;

	typedef struct {
		logic              cmd;
		logic [IdW-1:0]    id;
		logic [StartW-1:0] start;
		logic [DurW-1:0]   dur;
		pin_t              pin;
		logic [IdW-1:0]    exp_id;
		logic [StatusW-1:0] exp_st;
	} row_t;

	typedef struct {
		logic [IdW-1:0]     id;
		logic [StatusW-1:0] status;
		logic               last;
	} completion_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// Predictor state: the running task, the pause stack and the latest start.
	logic              run_valid;
	logic [IdW-1:0]    run_id;
	logic [EndW-1:0]   run_end;
	logic [StartW-1:0] prev_start;
	logic [IdW-1:0]    pause_id [SLOTS];
	logic [RemW-1:0]   pause_rem [SLOTS];
	int                pause_cnt;

	// Completions still owed by the block, kept as a ring with free-running
	// write and read counts.
	completion_t exp_buf [EXP_DEPTH];
	int          exp_wr = 0;
	int          exp_rd = 0;
	int          step_n;      // completions produced by the current item
	int          mismatches = 0;
	int          cycle_cnt = 0;
	bit          hold_wanted = 1'b0;
	bit          hold_done = 1'b0;
	completion_t head_c;

	// Directed stimulus table.
	row_t        plan [PLAN_SLOTS];
	int          plan_n = 0;

	lifo_preemptive_task_order #(.STACK_DEPTH(SLOTS)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #1 clk = ~clk;

	// Hard stop in case the block hangs on either side.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_CAP) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_pause();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_row(input row_t r);
		plan[plan_n] = r;
		plan_n++;
	endtask

	task automatic queue_result(input completion_t c);
		exp_buf[exp_wr % EXP_DEPTH] = c;
		exp_wr++;
	endtask

	task automatic note_completion(input logic [IdW-1:0] id, input logic [StatusW-1:0] st,
			input bit keep);
		completion_t c;
		c.id = id;
		c.status = st;
		c.last = 1'b0;
		if (keep)
			queue_result(c);
		step_n++;
	endtask

	task automatic clear_schedule();
		run_valid = 1'b0;
		run_id = '0;
		run_end = '0;
		prev_start = '0;
		pause_cnt = 0;
	endtask

	// Scheduler predictor. Works out which tasks complete because of one
	// accepted item and, when keep is set, queues them as expected results.
	task automatic sched_step(input logic cmd, input logic [IdW-1:0] id,
			input logic [StartW-1:0] start, input logic [DurW-1:0] dur, input bit keep);
		logic [EndW-1:0] idle;
		step_n = 0;
		if (cmd == CMD_FLUSH) begin
			// Drain the running task first, then the stack from the top down.
			if (run_valid)
				note_completion(run_id, ST_OK, keep);
			while (pause_cnt > 0) begin
				pause_cnt--;
				note_completion(pause_id[pause_cnt], ST_OK, keep);
			end
			clear_schedule();
		end else if (start < prev_start) begin
			// Out-of-order arrival is rejected and leaves the state alone.
			note_completion('0, ST_ORDER, keep);
		end else begin
			if (run_valid) begin
				if (EndW'(start) < run_end) begin
					// Preemption: park the running task with what it has left,
					// or drop it when the stack has no room.
					if (pause_cnt < SLOTS) begin
						pause_id[pause_cnt] = run_id;
						pause_rem[pause_cnt] = RemW'(run_end - EndW'(start));
						pause_cnt++;
					end else begin
						note_completion(run_id, ST_OVERFLOW, keep);
					end
				end else begin
					// The running task finished; the idle gap resumes paused
					// tasks newest first until the gap is used up.
					idle = EndW'(start) - run_end;
					note_completion(run_id, ST_OK, keep);
					while (idle > 0 && pause_cnt > 0) begin
						if (idle >= EndW'(pause_rem[pause_cnt-1])) begin
							idle = idle - EndW'(pause_rem[pause_cnt-1]);
							pause_cnt--;
							note_completion(pause_id[pause_cnt], ST_OK, keep);
						end else begin
							pause_rem[pause_cnt-1] = pause_rem[pause_cnt-1] - RemW'(idle);
							idle = '0;
						end
					end
				end
			end
			run_valid = 1'b1;
			run_id = id;
			run_end = EndW'(start) + EndW'(dur);
			prev_start = start;
		end
		if (keep && step_n > 0)
			exp_buf[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
	endtask

	// Offers one item after an optional gap and returns at the edge where the
	// transfer happens. Called at a rising edge.
	task automatic offer_item(input logic cmd, input logic [IdW-1:0] id,
			input logic [StartW-1:0] start, input logic [DurW-1:0] dur, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, dur, start, id};
		s_axis_tuser <= cmd;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Receiver: runs of ready broken by stalls, plus one long hold that lets
	// the block fill up and push back on its input.
	initial begin
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_wanted && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			if ($urandom_range(19) == 0)
				repeat ($urandom_range(60, 150)) @(posedge clk);
			else
				repeat ($urandom_range(1, 20)) @(posedge clk);
			begin : stall
				int s;
				s = pick_pause();
				if (s > 0) begin
					m_axis_tready <= 1'b0;
					repeat (s) @(posedge clk);
				end
			end
		end
	end

	// Result checker: each transfer on m_axis must match the oldest completion.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (exp_rd == exp_wr) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("tb: unexpected result id=%0d status=%0d last=%0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				head_c = exp_buf[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (m_axis_tdata !== {6'b0, head_c.id} || m_axis_tuser !== head_c.status
						|| m_axis_tlast !== head_c.last) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("tb: mismatch exp id=%0d st=%0d last=%0b, got %0d %0d %0b",
							head_c.id, head_c.status, head_c.last,
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end
			end
		end
	end

	// Stimulus: reset, directed table, random items, then drain and verdict.
	initial begin : stimulus
		row_t              row;
		completion_t       pinned;
		logic              cmd;
		logic [IdW-1:0]    id;
		logic [StartW-1:0] start;
		logic [DurW-1:0]   dur;
		int                r;
		int                nxt;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= CMD_TASK;
		clear_schedule();

		// First arrival after reset only starts running, at the id extreme.
		add_row('{CMD_TASK, 10'd1023, 11'd0, 10'd1023, PIN_SILENT, 10'd0, ST_OK});
		// Zero-length task preempts; the next arrival at the same minute
		// completes it with no idle gap.
		add_row('{CMD_TASK, 10'd5, 11'd0, 10'd0, PIN_PREDICT, 10'd0, ST_OK});
		add_row('{CMD_TASK, 10'd6, 11'd0, 10'd10, PIN_PREDICT, 10'd0, ST_OK});
		// Start exactly at the running task's end.
		add_row('{CMD_TASK, 10'd7, 11'd10, 10'd1, PIN_PREDICT, 10'd0, ST_OK});
		// Long idle gap resumes and completes the parked task.
		add_row('{CMD_TASK, 10'd8, 11'd2000, 10'd5, PIN_PREDICT, 10'd0, ST_OK});
		// Out-of-order arrival.
		add_row('{CMD_TASK, 10'd9, 11'd3, 10'd1, PIN_ONE, 10'd0, ST_ORDER});
		// Latest start minute with the longest duration, id zero.
		add_row('{CMD_TASK, 10'd0, 11'd2047, 10'd1023, PIN_PREDICT, 10'd0, ST_OK});
		add_row('{CMD_FLUSH, 10'd0, 11'd0, 10'd0, PIN_PREDICT, 10'd0, ST_OK});
		// Flush with nothing running and nothing parked.
		add_row('{CMD_FLUSH, 10'd1023, 11'd2047, 10'd1023, PIN_SILENT, 10'd0, ST_OK});
		// Fill the pause stack, then overflow it, then drain it all.
		add_row('{CMD_TASK, 10'd100, 11'd0, 10'd1023, PIN_SILENT, 10'd0, ST_OK});
		for (int k = 1; k <= SLOTS; k++)
			add_row('{CMD_TASK, IdW'(100 + k), StartW'(k), 10'd1023, PIN_PREDICT,
				10'd0, ST_OK});
		add_row('{CMD_TASK, 10'd117, 11'd17, 10'd1023, PIN_ONE, 10'd116, ST_OVERFLOW});
		add_row('{CMD_FLUSH, 10'd0, 11'd0, 10'd0, PIN_PREDICT, 10'd0, ST_OK});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < plan_n; i++) begin
			row = plan[i];
			offer_item(row.cmd, row.id, row.start, row.dur, pick_pause());
			if (row.pin == PIN_PREDICT) begin
				sched_step(row.cmd, row.id, row.start, row.dur, 1'b1);
			end else begin
				sched_step(row.cmd, row.id, row.start, row.dur, 1'b0);
				if (row.pin == PIN_ONE) begin
					pinned.id = row.exp_id;
					pinned.status = row.exp_st;
					pinned.last = 1'b1;
					queue_result(pinned);
				end
			end
		end

		// Random part. Most items are in-order arrivals with small steps so
		// that preemptions stack up; larger steps let the stack unwind.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 40)
				hold_wanted = 1'b1;
			r = $urandom_range(99);
			cmd = CMD_TASK;
			id = IdW'($urandom_range(1023));
			start = StartW'($urandom_range(2047));
			dur = DurW'($urandom_range(1023));
			if (r < 4) begin
				cmd = CMD_FLUSH;
			end else if (r < 9 && prev_start > 0) begin
				start = StartW'($urandom_range(prev_start - 1));
			end else if (r >= 12) begin
				r = $urandom_range(99);
				if (r < 60)
					nxt = prev_start + $urandom_range(0, 8);
				else if (r < 90)
					nxt = prev_start + $urandom_range(10, 200);
				else
					nxt = prev_start + $urandom_range(200, 1200);
				// Past the largest start minute the batch is closed instead.
				if (nxt > 2047)
					cmd = CMD_FLUSH;
				else
					start = StartW'(nxt);
				r = $urandom_range(99);
				if (r < 50)
					dur = DurW'($urandom_range(1, 40));
				else if (r < 85)
					dur = DurW'($urandom_range(40, 400));
				else if (r < 97)
					dur = DurW'($urandom_range(400, 1023));
				else
					dur = '0;
			end
			offer_item(cmd, id, start, dur, pick_pause());
			sched_step(cmd, id, start, dur, 1'b1);
		end
		s_axis_tvalid <= 1'b0;

		while (exp_rd != exp_wr)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		if (mismatches == 0 && exp_rd == exp_wr)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
